/* hw/rtl/pab_pkg.sv */
// Shared types and constants of the palette alpha pixel blend engine.
package pab_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned RGBA_W     = 32;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned MIX_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_ENABLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_RGB     = 2'd2;

  localparam logic REQ_PAL_WRITE = 1'b0;
  localparam logic REQ_PIXEL     = 1'b1;

  localparam logic [CHAN_W-1:0] BYTE_MASK = 8'hFF;

  typedef enum logic [1:0] {
    MODE_COPY       = 2'd0,
    MODE_PAL_BLEND  = 2'd1,
    MODE_RGBA_BLEND = 2'd2,
    MODE_RGBA_ALT   = 2'd3
  } blend_mode_e;

  typedef struct packed {
    logic copy;
    logic pal_src;
    logic in_range;
  } pix_ctrl_t;

endpackage

/* hw/rtl/pab_req_if.sv */
// Request channel: palette writes and pixels.
interface pab_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  color_index;
  logic [31:0] source_rgba;
  logic [31:0] dest_rgba;

  modport source (output valid, req_type, color_index, source_rgba, dest_rgba, input ready);
  modport sink   (input valid, req_type, color_index, source_rgba, dest_rgba, output ready);
endinterface

/* hw/rtl/pab_rsp_if.sv */
// Result channel: blended or copied pixels.
interface pab_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_rgba;

  modport source (output valid, out_rgba, input ready);
  modport sink   (input valid, out_rgba, output ready);
endinterface

/* hw/rtl/pab_palette.sv */
// Palette memory: one write port, one registered read port.
module pab_palette #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/pab_mix.sv */
// Source and destination selection, channel multiply stage and result register.
module pab_mix
  import pab_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  en_i,
  input  pix_ctrl_t             ctrl_i,
  input  logic [RGBA_W-1:0]     pal_i,
  input  logic [RGBA_W-1:0]     src_i,
  input  logic [RGBA_W-1:0]     dst_i,
  input  logic                  bg_en_i,
  input  logic [CFG_DATA_W-1:0] bg_rgb_i,
  output logic [RGBA_W-1:0]     out_rgba_o
);

  logic [RGBA_W-1:0] pal_word;
  logic [RGBA_W-1:0] src_sel;
  logic [RGBA_W-1:0] dst_sel;
  logic [MIX_W-1:0]  sum_d [NUM_CHAN];
  logic [MIX_W-1:0]  sum_q [NUM_CHAN];
  logic              copy_q;
  logic [RGBA_W-1:0] copy_word_q;
  logic [RGBA_W-1:0] out_d;
  logic [RGBA_W-1:0] out_q;

  always_comb begin
    logic [CHAN_W-1:0] a;
    logic [CHAN_W:0]   na;
    logic [CHAN_W-1:0] s;
    logic [CHAN_W-1:0] d;
    logic [MIX_W:0]    prod;
    pal_word = ctrl_i.in_range ? pal_i : '0;
    src_sel  = ctrl_i.pal_src ? pal_word : src_i;
    dst_sel  = bg_en_i ? {bg_rgb_i, BYTE_MASK} : dst_i;
    a        = src_sel[CHAN_W-1:0];
    na       = 9'd256 - {1'b0, a};
    for (int c = 0; c < NUM_CHAN; c++) begin
      s        = src_sel[CHAN_W*(c+1) +: CHAN_W];
      d        = dst_sel[CHAN_W*(c+1) +: CHAN_W];
      prod     = 17'(d) * 17'(na) + 17'(s) * 17'(a);
      sum_d[c] = prod[MIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      copy_q      <= ctrl_i.copy;
      copy_word_q <= pal_word;
      for (int c = 0; c < NUM_CHAN; c++) begin
        sum_q[c] <= sum_d[c];
      end
    end
  end

  always_comb begin
    out_d = copy_q ? copy_word_q
                   : {sum_q[2][MIX_W-1 -: CHAN_W], sum_q[1][MIX_W-1 -: CHAN_W],
                      sum_q[0][MIX_W-1 -: CHAN_W], {CHAN_W{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_rgba_o = out_q;

endmodule

/* hw/rtl/palette_alpha_pixel_blend.sv */
// Top level of the palette alpha pixel blend engine.
//
//   channel   dir  beat payload                                    valid/ready
//   req       in   req_type, color_index, source_rgba, dest_rgba  req.valid/ready
//   rsp       out  out_rgba                                       rsp.valid/ready
//   cfg       in   cfg_idx_i, cfg_data_i                          cfg_we_i only
//
// One beat per cycle in, one per cycle out while the output is not stalled; a pixel
// passes the palette read, channel multiply and result register stages before it leaves.
// Palette writes give no result beat.
// A stalled output freezes all three stages; req.ready drops with it.
// Reset clears the valid bits and configuration; palette contents stay unknown.
module palette_alpha_pixel_blend
  import pab_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pab_req_if.sink               req,
  pab_rsp_if.source             rsp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  blend_mode_e           blend_mode_q;
  logic                  bg_en_q;
  logic [CFG_DATA_W-1:0] bg_rgb_q;

  logic              adv;
  logic              accept;
  logic              in_range;
  logic              v1_q;
  logic              v2_q;
  logic              out_valid_q;
  pix_ctrl_t         ctrl1_d;
  pix_ctrl_t         ctrl1_q;
  logic [RGBA_W-1:0] src1_q;
  logic [RGBA_W-1:0] dst1_q;
  logic [RGBA_W-1:0] pal_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q <= MODE_COPY;
      bg_en_q      <= 1'b0;
      bg_rgb_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLEND_MODE: blend_mode_q <= blend_mode_e'(cfg_data_i[1:0]);
        CFG_BG_ENABLE:  bg_en_q      <= cfg_data_i[0];
        CFG_BG_RGB:     bg_rgb_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign adv       = !out_valid_q || rsp.ready;
  assign req.ready = adv;
  assign accept    = req.valid && adv;
  assign in_range  = ({1'b0, req.color_index} < 9'(PALETTE_DEPTH));

  always_comb begin
    ctrl1_d.copy     = (blend_mode_q == MODE_COPY);
    ctrl1_d.pal_src  = (blend_mode_q == MODE_PAL_BLEND);
    ctrl1_d.in_range = in_range;
  end

  pab_palette #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (accept && (req.req_type == REQ_PAL_WRITE) && in_range),
    .waddr_i (req.color_index[AW-1:0]),
    .wdata_i (req.source_rgba),
    .re_i    (accept && (req.req_type == REQ_PIXEL)),
    .raddr_i (req.color_index[AW-1:0]),
    .rdata_o (pal_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= accept && (req.req_type == REQ_PIXEL);
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (req.req_type == REQ_PIXEL)) begin
      ctrl1_q <= ctrl1_d;
      src1_q  <= req.source_rgba;
      dst1_q  <= req.dest_rgba;
    end
  end

  pab_mix u_mix (
    .clk_i      (clk_i),
    .en_i       (adv),
    .ctrl_i     (ctrl1_q),
    .pal_i      (pal_rdata),
    .src_i      (src1_q),
    .dst_i      (dst1_q),
    .bg_en_i    (bg_en_q),
    .bg_rgb_i   (bg_rgb_q),
    .out_rgba_o (rsp.out_rgba)
  );

  assign rsp.valid = out_valid_q;

  a_write_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req.req_type == REQ_PAL_WRITE)) |=> !v1_q)
    else $error("palette write entered the pixel pipeline");

  a_pixel_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req.req_type == REQ_PIXEL)) |=> v1_q)
    else $error("accepted pixel lost at stage one");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> (v1_q == $past(v1_q)) && (v2_q == $past(v2_q)))
    else $error("pipeline moved during output stall");

endmodule

/* verif/tb_palette_alpha_pixel_blend.sv */
// Self-checking testbench of the palette alpha pixel blend engine.
module tb_palette_alpha_pixel_blend;
  timeunit 1ns;
  timeprecision 1ps;
  import pab_pkg::*;

  localparam int unsigned PAL_DEPTH    = 256;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_BEATS  = 116;
  localparam int unsigned DRAIN_CYCLES = 5;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned QUIET_LIMIT  = 2000;

  typedef struct packed {
    logic               req_type;
    logic [INDEX_W-1:0] color_index;
    logic [RGBA_W-1:0]  source_rgba;
    logic [RGBA_W-1:0]  dest_rgba;
  } pix_req_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    pix_req_t              beat;
    logic                  known;
    logic [RGBA_W-1:0]     known_rgba;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pab_req_if req_ch ();
  pab_rsp_if rsp_ch ();

  palette_alpha_pixel_blend #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  logic [RGBA_W-1:0]     pal_words [PAL_DEPTH];
  bit                    pal_set [PAL_DEPTH];
  logic [INDEX_W-1:0]    pal_used [$];
  blend_mode_e           cur_mode = MODE_COPY;
  logic                  cur_bg_en = 1'b0;
  logic [CFG_DATA_W-1:0] cur_bg_rgb = '0;
  logic [RGBA_W-1:0]     out_rgba_due [$];
  dir_row_t              directed_rows [$];
  int unsigned           mismatches = 0;
  int unsigned           send_idle_pct = 0;
  int unsigned           stall_pct = 0;
  logic [3:0]            hold_token = '0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [RGBA_W-1:0] mix_rgb(logic [RGBA_W-1:0] s, logic [RGBA_W-1:0] d);
    logic [RGBA_W-1:0] res;
    int unsigned       a, mix, c;
    a   = 32'(s[CHAN_W-1:0]);
    res = '0;
    for (c = 1; c <= NUM_CHAN; c++) begin
      mix = d[c*CHAN_W +: CHAN_W] * (256 - a) + s[c*CHAN_W +: CHAN_W] * a;
      res[c*CHAN_W +: CHAN_W] = mix[15:8];
    end
    return res;
  endfunction

  function automatic logic [RGBA_W-1:0] predict_out_rgba(pix_req_t it);
    logic [RGBA_W-1:0] pal, s, d;
    pal = (it.color_index < PAL_DEPTH) ? pal_words[it.color_index] : '0;
    if (cur_mode == MODE_COPY) return pal;
    s = (cur_mode == MODE_PAL_BLEND) ? pal : it.source_rgba;
    d = cur_bg_en ? {cur_bg_rgb, BYTE_MASK} : it.dest_rgba;
    return mix_rgb(s, d);
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic dir_row_t wr_row(logic [INDEX_W-1:0] idx, logic [RGBA_W-1:0] word);
    dir_row_t r;
    r                  = '0;
    r.beat.req_type    = REQ_PAL_WRITE;
    r.beat.color_index = idx;
    r.beat.source_rgba = word;
    return r;
  endfunction

  function automatic dir_row_t px_row(logic [INDEX_W-1:0] idx, logic [RGBA_W-1:0] src,
                                      logic [RGBA_W-1:0] dst);
    dir_row_t r;
    r                  = '0;
    r.beat.req_type    = REQ_PIXEL;
    r.beat.color_index = idx;
    r.beat.source_rgba = src;
    r.beat.dest_rgba   = dst;
    return r;
  endfunction

  function automatic dir_row_t px_typed(logic [INDEX_W-1:0] idx, logic [RGBA_W-1:0] src,
                                        logic [RGBA_W-1:0] dst, logic [RGBA_W-1:0] want);
    dir_row_t r;
    r            = px_row(idx, src, dst);
    r.known      = 1'b1;
    r.known_rgba = want;
    return r;
  endfunction

  task automatic send_beat(input pix_req_t it, input logic known,
                           input logic [RGBA_W-1:0] known_rgba);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= it.req_type;
    req_ch.color_index <= it.color_index;
    req_ch.source_rgba <= it.source_rgba;
    req_ch.dest_rgba   <= it.dest_rgba;
    do @(posedge clk_i); while (!req_ch.ready);
    if (it.req_type == REQ_PAL_WRITE) begin
      if (it.color_index < PAL_DEPTH) begin
        pal_words[it.color_index] = it.source_rgba;
        if (!pal_set[it.color_index]) begin
          pal_set[it.color_index] = 1'b1;
          pal_used.push_back(it.color_index);
        end
      end
    end else begin
      out_rgba_due.push_back(known ? known_rgba : predict_out_rgba(it));
    end
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (out_rgba_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_BLEND_MODE: cur_mode = blend_mode_e'(val[1:0]);
      CFG_BG_ENABLE:  cur_bg_en = val[0];
      CFG_BG_RGB:     cur_bg_rgb = val;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    pix_req_t    it;
    blend_mode_e mode;
    int unsigned ph, n;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_BLEND_MODE;
    cfg_data_i         <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_PAL_WRITE;
    req_ch.color_index <= '0;
    req_ch.source_rgba <= '0;
    req_ch.dest_rgba   <= '0;
    directed_rows = '{
      wr_row(8'd0,   32'h0000_0000),
      wr_row(8'd255, 32'hFFFF_FFFF),
      wr_row(8'd1,   32'h8040_2010),
      px_typed(8'd0,   32'h0000_0000, 32'h1234_5678, 32'h0000_0000),
      px_typed(8'd255, 32'h0000_0000, 32'h1234_5678, 32'hFFFF_FFFF),
      px_typed(8'd1,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8040_2010),
      cfg_row(CFG_BLEND_MODE, 24'(MODE_PAL_BLEND)),
      px_typed(8'd0,   32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FF00),
      px_typed(8'd255, 32'h0000_0000, 32'h0000_0000, 32'hFEFE_FE00),
      px_row(8'd1, 32'h0000_0000, 32'h1122_3344),
      cfg_row(CFG_BG_RGB, 24'hFF_FFFF),
      cfg_row(CFG_BG_ENABLE, 24'd1),
      px_typed(8'd0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FF00),
      px_row(8'd1, 32'h0000_0000, 32'h5566_7788),
      cfg_row(CFG_BLEND_MODE, 24'(MODE_RGBA_BLEND)),
      px_typed(8'd0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FF00),
      px_typed(8'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FF00),
      cfg_row(CFG_BG_ENABLE, 24'd0),
      px_typed(8'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFEFE_FE00),
      px_row(8'd0, 32'h1234_5680, 32'hFEDC_BA98),
      cfg_row(CFG_BLEND_MODE, 24'(MODE_RGBA_ALT)),
      px_typed(8'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFEFE_FE00),
      px_row(8'd0, 32'hA5A5_A5FF, 32'h5A5A_5A00),
      wr_row(8'd2, 32'hDEAD_BEEF),
      cfg_row(CFG_BG_RGB, 24'h12_3456),
      cfg_row(CFG_BG_ENABLE, 24'd1),
      cfg_row(CFG_BLEND_MODE, 24'(MODE_COPY)),
      px_typed(8'd2, 32'h0000_0000, 32'h0000_0000, 32'hDEAD_BEEF),
      wr_row(8'd2, 32'h0102_0304),
      px_typed(8'd2, 32'h0000_0000, 32'h0000_0000, 32'h0102_0304),
      px_typed(8'd255, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF)
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_beat(directed_rows[i].beat, directed_rows[i].known, directed_rows[i].known_rgba);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      mode = blend_mode_e'((ph * 3 + 1) % 4);
      write_reg(CFG_BLEND_MODE, {22'($urandom()), mode});
      write_reg(CFG_BG_ENABLE, {23'($urandom()), 1'(((ph >> 2) ^ ph) & 1)});
      write_reg(CFG_BG_RGB, (ph == 0) ? 24'h00_0000 :
                            (ph == 1) ? 24'hFF_FFFF : 24'($urandom()));
      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct <= 0;  end
        1:       begin send_idle_pct = 64; stall_pct <= 0;  end
        2:       begin send_idle_pct = 0;  stall_pct <= 64; end
        default: begin send_idle_pct = 32; stall_pct <= 32; end
      endcase
      // hold the sink off long enough to back the pipeline up
      if (ph == 2) hold_token <= hold_token + 1'b1;
      for (n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 5 && n == PHASE_BEATS / 2) settle();
        it.req_type = ($urandom_range(0, 3) == 0) ? REQ_PAL_WRITE : REQ_PIXEL;
        it.color_index = (it.req_type == REQ_PAL_WRITE) ? INDEX_W'($urandom_range(0, 255)) :
                         pal_used[$urandom_range(0, pal_used.size() - 1)];
        it.source_rgba = $urandom();
        case ($urandom_range(0, 5))
          0:       it.source_rgba[7:0] = 8'h00;
          1:       it.source_rgba[7:0] = 8'hFF;
          default: ;
        endcase
        it.dest_rgba = $urandom();
        send_beat(it, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("palette_alpha_pixel_blend test passed");
    end else begin
      $display("palette_alpha_pixel_blend test failed");
    end
    $finish;
  end

  initial begin : receiver
    logic [3:0]  hold_seen;
    int unsigned hold_left;
    hold_seen = '0;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    logic [RGBA_W-1:0] due;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (out_rgba_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual %08h",
                 $time, rsp_ch.out_rgba);
      end else begin
        due = out_rgba_due.pop_front();
        if (rsp_ch.out_rgba !== due) begin
          mismatches++;
          $display("%0t: out_rgba mismatch, expected %08h, actual %08h",
                   $time, due, rsp_ch.out_rgba);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("palette_alpha_pixel_blend test failed");
    $finish;
  end

endmodule
